// ===== rtl/pcds_pkg.sv =====
// Package: shared constants and types for the PWM clock divider search.
`timescale 1ns / 1ps
package pcds_pkg;

    localparam int FREQ_W           = 32;
    localparam int MCK_W            = 32;
    localparam int PRESC_W          = 8;
    localparam int IDX_FIELD_W      = 4;
    localparam int SETTING_W        = PRESC_W + IDX_FIELD_W;
    localparam int HALF_SHIFT       = 16;
    localparam int MODE_W           = HALF_SHIFT + SETTING_W;
    localparam int NUM_DIVISORS_DEF = 11;
    localparam logic [MCK_W-1:0] MCK_RESET = MCK_W'(48000000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEARCH,
        ST_DIVIDE,
        ST_WRITE,
        ST_NEXT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_FAIL,
        WR_SET
    } t_wr_sel;

    typedef struct packed {
        logic    capture;
        logic    load;
        logic    shift;
        logic    div_init;
        logic    div_step;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    chan;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic freq_zero;
        logic fits;
        logic idx_last;
        logic bit_last;
    } t_dp_stat;

endpackage

// ===== rtl/pcds_in_if.sv =====
// Interface: input transaction channel carrying the two wanted frequencies.
`timescale 1ns / 1ps
interface pcds_in_if;
    import pcds_pkg::*;

    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] clock_a_freq;
    logic [FREQ_W-1:0] clock_b_freq;

    modport source (output valid, output clock_a_freq, output clock_b_freq, input ready);
    modport sink   (input valid, input clock_a_freq, input clock_b_freq, output ready);
endinterface

// ===== rtl/pcds_out_if.sv =====
// Interface: result transaction channel carrying the settings and mode word.
`timescale 1ns / 1ps
interface pcds_out_if;
    import pcds_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SETTING_W-1:0] setting_a;
    logic [SETTING_W-1:0] setting_b;
    logic [MODE_W-1:0]    mode_word;
    logic                 a_unreachable;
    logic                 b_unreachable;

    modport source (output valid, output setting_a, output setting_b, output mode_word,
                    output a_unreachable, output b_unreachable, input ready);
    modport sink   (input valid, input setting_a, input setting_b, input mode_word,
                    input a_unreachable, input b_unreachable, output ready);
endinterface

// ===== rtl/pcds_ctrl.sv =====
// Controller: sequences the divisor search and prescaler division per channel.
`timescale 1ns / 1ps
module pcds_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  pcds_pkg::t_dp_stat i_stat,
    output pcds_pkg::t_dp_cmd  o_cmd
);
    import pcds_pkg::*;

    t_state r_state, n_state;
    logic   r_chan, n_chan;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chan      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chan      <= n_chan;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_chan       = r_chan;
        n_out_valid  = r_out_valid;
        o_cmd        = '0;
        o_cmd.wr_sel = WR_ZERO;
        o_cmd.chan   = r_chan;
        o_in_ready   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_chan        = 1'b0;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_stat.freq_zero) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_ZERO;
                    n_state      = ST_NEXT;
                end else begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_stat.fits) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIVIDE;
                end else if (i_stat.idx_last) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_FAIL;
                    n_state      = ST_NEXT;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.bit_last) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SET;
                n_state      = ST_NEXT;
            end
            ST_NEXT: begin
                if (!r_chan) begin
                    n_chan  = 1'b1;
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // output register must be free or emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/pcds_dp.sv =====
// Datapath: master clock register, divisor search shifter and prescaler divider.
`timescale 1ns / 1ps
module pcds_dp #(
    parameter int NUM_DIVISORS = pcds_pkg::NUM_DIVISORS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pcds_pkg::MCK_W-1:0]     i_cfg_wr_data,
    input  logic [pcds_pkg::FREQ_W-1:0]    i_clock_a_freq,
    input  logic [pcds_pkg::FREQ_W-1:0]    i_clock_b_freq,
    input  pcds_pkg::t_dp_cmd              i_cmd,
    output pcds_pkg::t_dp_stat             o_stat,
    output logic [pcds_pkg::SETTING_W-1:0] o_setting_a,
    output logic [pcds_pkg::SETTING_W-1:0] o_setting_b,
    output logic [pcds_pkg::MODE_W-1:0]    o_mode_word,
    output logic                           o_a_unreachable,
    output logic                           o_b_unreachable
);
    import pcds_pkg::*;

    localparam int IDX_W = (NUM_DIVISORS > 1) ? $clog2(NUM_DIVISORS) : 1;
    localparam int BIT_W = $clog2(PRESC_W);
    localparam int DSR_W = FREQ_W + PRESC_W - 1;
    localparam int CMP_W = FREQ_W + PRESC_W;

    logic [MCK_W-1:0]     r_mck;
    logic [FREQ_W-1:0]    r_freq_a, r_freq_b;
    logic [MCK_W-1:0]     r_dvd;       // master clock shifted by the divisor index
    logic [IDX_W-1:0]     r_idx;
    logic [DSR_W-1:0]     r_dsr;       // divisor aligned to the current quotient bit
    logic [BIT_W-1:0]     r_bit;
    logic [PRESC_W-1:0]   r_quot;
    logic [SETTING_W-1:0] r_set_a, r_set_b;
    logic                 r_fail_a, r_fail_b;
    logic [SETTING_W-1:0] r_o_set_a, r_o_set_b;
    logic                 r_o_fail_a, r_o_fail_b;

    logic [FREQ_W-1:0]    cur_f;
    logic                 ge;
    logic [SETTING_W-1:0] wr_set;
    logic                 wr_fail;

    assign cur_f = i_cmd.chan ? r_freq_b : r_freq_a;
    assign ge    = {{(CMP_W-MCK_W){1'b0}}, r_dvd} >= {1'b0, r_dsr};

    assign o_stat.freq_zero = (cur_f == '0);
    assign o_stat.fits      = {{(CMP_W-MCK_W){1'b0}}, r_dvd} < {cur_f, {PRESC_W{1'b0}}};
    assign o_stat.idx_last  = (r_idx == IDX_W'(NUM_DIVISORS - 1));
    assign o_stat.bit_last  = (r_bit == '0);

    always_comb begin
        wr_set  = '0;
        wr_fail = 1'b0;
        case (i_cmd.wr_sel)
            WR_FAIL: wr_fail = 1'b1;
            WR_SET:  wr_set  = {IDX_FIELD_W'(r_idx), r_quot};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mck <= MCK_RESET;
        end else if (i_cfg_wr_en) begin
            r_mck <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_freq_a <= i_clock_a_freq;
            r_freq_b <= i_clock_b_freq;
        end
        if (i_cmd.load) begin
            r_dvd <= r_mck;
            r_idx <= '0;
        end else if (i_cmd.shift) begin
            r_dvd <= r_dvd >> 1;
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.div_step && ge) begin
            r_dvd <= r_dvd - r_dsr[MCK_W-1:0];
        end
        if (i_cmd.div_init) begin
            r_dsr  <= {cur_f, {(PRESC_W-1){1'b0}}};
            r_bit  <= BIT_W'(PRESC_W - 1);
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_dsr  <= r_dsr >> 1;
            r_bit  <= r_bit - 1'b1;
            r_quot <= {r_quot[PRESC_W-2:0], ge};
        end
        if (i_cmd.wr_en) begin
            if (i_cmd.chan) begin
                r_set_b  <= wr_set;
                r_fail_b <= wr_fail;
            end else begin
                r_set_a  <= wr_set;
                r_fail_a <= wr_fail;
            end
        end
        if (i_cmd.out_load) begin
            r_o_set_a  <= r_set_a;
            r_o_set_b  <= r_set_b;
            r_o_fail_a <= r_fail_a;
            r_o_fail_b <= r_fail_b;
        end
    end

    assign o_setting_a     = r_o_set_a;
    assign o_setting_b     = r_o_set_b;
    assign o_mode_word     = {r_o_set_b, {(HALF_SHIFT-SETTING_W){1'b0}}, r_o_set_a};
    assign o_a_unreachable = r_o_fail_a;
    assign o_b_unreachable = r_o_fail_b;

endmodule

// ===== rtl/pwm_clock_divider_search.sv =====
// Computation: the one-step-per-cycle divisor search and the restoring prescaler divider,
// run for clock A and then clock B.
// Throughput: one transaction at a time; the next is taken once the result is registered,
// which waits while the previous result still sits unaccepted in the output register.
// Reset: synchronous, active low; master clock register returns to 48000000.
`timescale 1ns / 1ps
module pwm_clock_divider_search #(
    parameter int NUM_DIVISORS = pcds_pkg::NUM_DIVISORS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [pcds_pkg::MCK_W-1:0] i_cfg_wr_data,
    pcds_in_if.sink                    i_item,
    pcds_out_if.source                 o_result
);
    import pcds_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pcds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pcds_dp #(
        .NUM_DIVISORS (NUM_DIVISORS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_clock_a_freq  (i_item.clock_a_freq),
        .i_clock_b_freq  (i_item.clock_b_freq),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_setting_a     (o_result.setting_a),
        .o_setting_b     (o_result.setting_b),
        .o_mode_word     (o_result.mode_word),
        .o_a_unreachable (o_result.a_unreachable),
        .o_b_unreachable (o_result.b_unreachable)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input accepted a second transaction while busy");

    a_fail_zero_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.a_unreachable) |-> (o_result.setting_a == '0))
        else $error("clock A unreachable but setting non-zero");

    a_fail_zero_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.b_unreachable) |-> (o_result.setting_b == '0))
        else $error("clock B unreachable but setting non-zero");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            ((int'(o_result.setting_a[SETTING_W-1:PRESC_W]) < NUM_DIVISORS) &&
             (int'(o_result.setting_b[SETTING_W-1:PRESC_W]) < NUM_DIVISORS)))
        else $error("divisor index beyond divisor count");

endmodule

// ===== dv/tb_pwm_clock_divider_search.sv =====
// Testbench: self-checking test of the PWM clock divider search against its own predictor.
`timescale 1ns / 1ps
module tb_pwm_clock_divider_search;
    import pcds_pkg::*;

    localparam int NUM_DIVS      = NUM_DIVISORS_DEF;
    localparam int PRESC_LIMIT   = 255;
    localparam int SETTLE_CYCLES = 2 * (NUM_DIVS + 12) + 2 + 10;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 36;
    localparam int PHASE_ITEMS   = 78;
    localparam int NUM_PHASES    = 7;
    localparam int NUM_ROWS      = 16;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [SETTING_W-1:0] setting_a;
        logic [SETTING_W-1:0] setting_b;
        logic [MODE_W-1:0]    mode_word;
        logic                 a_unreachable;
        logic                 b_unreachable;
    } t_mode_result;

    typedef struct packed {
        logic              load_clock;
        logic [MCK_W-1:0]  clock_hz;
        logic [FREQ_W-1:0] freq_a;
        logic [FREQ_W-1:0] freq_b;
        logic              fixed;
        t_mode_result      result;
    } t_dir_row;

    // Rows with fixed set carry a hand-worked result; the rest go through the predictor.
    localparam t_dir_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{1'b0, 32'd0,         32'd0,          32'd0,          1'b1,
          '{12'h000, 12'h000, 28'h0000000, 1'b0, 1'b0}},
        '{1'b0, 32'd0,         32'd1,          32'hFFFFFFFF,   1'b1,
          '{12'h000, 12'h000, 28'h0000000, 1'b1, 1'b0}},
        '{1'b0, 32'd0,         32'd188235,     32'd187500,     1'b0, '0},
        '{1'b0, 32'd0,         32'd184,        32'd183,        1'b0, '0},
        '{1'b0, 32'd0,         32'd1000,       32'd25000,      1'b0, '0},
        '{1'b0, 32'd0,         32'hAAAAAAAA,   32'h55555555,   1'b0, '0},
        '{1'b1, 32'hFFFFFFFF,  32'd1,          32'hFFFFFFFF,   1'b1,
          '{12'h000, 12'h001, 28'h0010000, 1'b1, 1'b0}},
        '{1'b0, 32'd0,         32'd1,          32'd1,          1'b1,
          '{12'h000, 12'h000, 28'h0000000, 1'b1, 1'b1}},
        '{1'b0, 32'd0,         32'h80000000,   32'd16843009,   1'b0, '0},
        '{1'b0, 32'd0,         32'd16384,      32'd16383,      1'b0, '0},
        '{1'b1, 32'd261120,    32'd1,          32'd1,          1'b1,
          '{12'hAFF, 12'hAFF, 28'h0AFF0AFF, 1'b0, 1'b0}},
        '{1'b0, 32'd0,         32'd2,          32'd0,          1'b0, '0},
        '{1'b1, 32'd1,         32'd1,          32'd2,          1'b0, '0},
        '{1'b0, 32'd0,         32'hFFFFFFFF,   32'd0,          1'b0, '0},
        '{1'b1, 32'd0,         32'd5,          32'hFFFFFFFF,   1'b1,
          '{12'h000, 12'h000, 28'h0000000, 1'b0, 1'b0}},
        '{1'b0, 32'd0,         32'd1,          32'd1,          1'b1, '0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [MCK_W-1:0] i_cfg_wr_data;

    pcds_in_if  in_ch ();
    pcds_out_if out_ch ();

    pwm_clock_divider_search DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (in_ch),
        .o_result      (out_ch)
    );

    t_mode_result     expected_modes [$];
    logic [MCK_W-1:0] master_clock_copy;
    logic             fixed_next;
    t_mode_result     fixed_result;
    logic             tx_idle_en;
    logic             rx_idle_en;
    int               stall_requests;
    int               quiet_cycles;
    int               items_taken;
    int               results_checked;
    int               clock_writes;
    int               mismatch_count;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // {unreachable, divisor index, prescaler} for one wanted frequency
    function automatic logic [SETTING_W:0] search_prescaler(input logic [MCK_W-1:0] mck,
                                                            input logic [FREQ_W-1:0] freq);
        logic [MCK_W-1:0] presc;
        if (freq == '0) begin
            return '0;
        end
        for (int d = 0; d < NUM_DIVS; d++) begin
            presc = (mck >> d) / freq;
            if (presc <= PRESC_LIMIT) begin
                return {1'b0, IDX_FIELD_W'(d), presc[PRESC_W-1:0]};
            end
        end
        return {1'b1, {SETTING_W{1'b0}}};
    endfunction

    function automatic t_mode_result predict_mode(input logic [MCK_W-1:0] mck,
                                                  input logic [FREQ_W-1:0] fa,
                                                  input logic [FREQ_W-1:0] fb);
        logic [SETTING_W:0] ra;
        logic [SETTING_W:0] rb;
        t_mode_result       r;
        ra = search_prescaler(mck, fa);
        rb = search_prescaler(mck, fb);
        r.setting_a     = ra[SETTING_W-1:0];
        r.setting_b     = rb[SETTING_W-1:0];
        r.mode_word     = MODE_W'(ra[SETTING_W-1:0]) | (MODE_W'(rb[SETTING_W-1:0]) << HALF_SHIFT);
        r.a_unreachable = ra[SETTING_W];
        r.b_unreachable = rb[SETTING_W];
        return r;
    endfunction

    // Mostly frequencies near the 255/256 prescaler boundary of some divisor index
    function automatic logic [FREQ_W-1:0] pick_frequency(input logic [MCK_W-1:0] mck);
        longint      near;
        int unsigned d;
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1, 2: begin
                return $urandom();
            end
            3: begin
                return $urandom_range(1, 1024);
            end
            default: begin
                d    = $urandom_range(0, NUM_DIVS - 1);
                near = longint'((mck >> d) >> PRESC_W) + longint'($urandom_range(0, 4)) - 2;
                if (near < 1) begin
                    return FREQ_W'(1);
                end
                return near[FREQ_W-1:0];
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : handshake_monitor
        t_mode_result want;
        t_mode_result seen;
        logic         moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            master_clock_copy = MCK_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                master_clock_copy = i_cfg_wr_data;
                clock_writes++;
            end
            // pop before push so a stray result cannot match the transaction taken now
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                results_checked++;
                seen = '{out_ch.setting_a, out_ch.setting_b, out_ch.mode_word,
                         out_ch.a_unreachable, out_ch.b_unreachable};
                if (expected_modes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("unexpected result: sa=%h sb=%h mode=%h ua=%b ub=%b",
                                 seen.setting_a, seen.setting_b, seen.mode_word,
                                 seen.a_unreachable, seen.b_unreachable);
                    end
                end else begin
                    want = expected_modes.pop_front();
                    if (seen.setting_a !== want.setting_a || seen.setting_b !== want.setting_b
                        || seen.mode_word !== want.mode_word
                        || seen.a_unreachable !== want.a_unreachable
                        || seen.b_unreachable !== want.b_unreachable) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("mismatch: want sa=%h sb=%h mode=%h ua=%b ub=%b",
                                     want.setting_a, want.setting_b, want.mode_word,
                                     want.a_unreachable, want.b_unreachable);
                            $display("          got  sa=%h sb=%h mode=%h ua=%b ub=%b",
                                     seen.setting_a, seen.setting_b, seen.mode_word,
                                     seen.a_unreachable, seen.b_unreachable);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                items_taken++;
                expected_modes.push_back(fixed_next ? fixed_result
                    : predict_mode(master_clock_copy, in_ch.clock_a_freq, in_ch.clock_b_freq));
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial begin : result_sink
        int hold_left;
        int stalls_served;
        hold_left     = 0;
        stalls_served = 0;
        out_ch.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stalls_served != stall_requests) begin
                stalls_served = stall_requests;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_idle_en) begin
                out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("tb_pwm_clock_divider_search: errors");
        $finish;
    end

    task automatic offer_frequencies(input logic [FREQ_W-1:0] freq_a,
                                     input logic [FREQ_W-1:0] freq_b,
                                     input logic fixed,
                                     input t_mode_result fixed_val);
        @(negedge i_clk);
        fixed_next   = fixed;
        fixed_result = fixed_val;
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.clock_a_freq <= freq_a;
        in_ch.clock_b_freq <= freq_b;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
    endtask

    // Leaves the block idle: input withdrawn, every result back, pipeline settled.
    task automatic drain_results;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_modes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_master_clock(input logic [MCK_W-1:0] hz);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= hz;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [MCK_W-1:0] phase_clocks [NUM_PHASES];
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        in_ch.valid        = 1'b0;
        in_ch.clock_a_freq = '0;
        in_ch.clock_b_freq = '0;
        fixed_next         = 1'b0;
        fixed_result       = '0;
        tx_idle_en         = 1'b1;
        rx_idle_en         = 1'b1;
        stall_requests     = 0;
        quiet_cycles       = 0;
        items_taken        = 0;
        results_checked    = 0;
        clock_writes       = 0;
        mismatch_count     = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].load_clock) begin
                write_master_clock(DIRECTED_ROWS[r].clock_hz);
            end
            offer_frequencies(DIRECTED_ROWS[r].freq_a, DIRECTED_ROWS[r].freq_b,
                              DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].result);
        end

        phase_clocks[0] = 32'd48000000;
        phase_clocks[1] = $urandom();
        phase_clocks[2] = 32'd100000000;
        phase_clocks[3] = 32'd1;
        phase_clocks[4] = 32'hFFFFFFFF;
        phase_clocks[5] = $urandom_range(1, 20000000);
        phase_clocks[6] = 32'd0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_master_clock(phase_clocks[p]);
            // phase 2 runs flat out on both sides; phase 3 starts with a long output hold-off
            tx_idle_en = (p != 2);
            rx_idle_en = (p != 2);
            if (p == 3) begin
                stall_requests++;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                offer_frequencies(pick_frequency(phase_clocks[p]),
                                  pick_frequency(phase_clocks[p]), 1'b0, '0);
            end
        end

        drain_results();
        $display("Covered %0d frequency pairs under %0d master clock writes plus the reset value,",
                 items_taken, clock_writes);
        $display("with %0d results compared and %0d mismatching.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_pwm_clock_divider_search: clean");
        end else begin
            $display("tb_pwm_clock_divider_search: errors");
        end
        $finish;
    end

endmodule
